/* rtl/core/magnitude_sorted_set_insert_unit_defines.svh */
// assertion macros shared by the checker
`ifndef MAGNITUDE_SORTED_SET_INSERT_UNIT_DEFINES_SVH
`define MAGNITUDE_SORTED_SET_INSERT_UNIT_DEFINES_SVH

// property checked at every clock edge outside reset
`define MSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    `MSI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/core/msi_pkg.sv */
package msi_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry;
        logic                      last;
        logic                      empty_res;
        logic                      overflowed;
    } result_t;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DUMP   = 1'b1;

    typedef struct packed {
        logic                      ins;
        logic                      rot;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry;
        logic                      valid;
        logic                      ahead;
    } cell_link_t;

    function automatic logic [VALUE_W:0] mag_of(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W:0] ext;
        ext = {v[VALUE_W-1], v};
        return v[VALUE_W-1] ? (~ext + 1'b1) : ext;
    endfunction

    // stored s sorts ahead of new v
    function automatic logic sorts_before(input logic signed [VALUE_W-1:0] s,
                                          input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W:0] ms;
        logic [VALUE_W:0] mv;
        ms = mag_of(s);
        mv = mag_of(v);
        if (ms != mv)
        begin
            return ms > mv;
        end
        return !s[VALUE_W-1] && v[VALUE_W-1];
    endfunction

endpackage

/* rtl/core/msi_cell.sv */
module msi_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msi_pkg::cell_ctrl_t                 ctrl,
    input  msi_pkg::cell_link_t                 prev,
    input  msi_pkg::cell_link_t                 next,
    input  logic signed [msi_pkg::VALUE_W-1:0]  head,
    output msi_pkg::cell_link_t                 link,
    output logic                                hit
);

    logic signed [msi_pkg::VALUE_W-1:0] entry_reg;
    logic signed [msi_pkg::VALUE_W-1:0] entry_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               ahead;
    logic                               at_pos;

    always_comb
    begin
        ahead      = valid_reg && msi_pkg::sorts_before(entry_reg, ctrl.value);
        at_pos     = prev.ahead && !ahead;
        hit        = at_pos && valid_reg && (entry_reg == ctrl.value);
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.ins)
        begin
            if (!ahead)
            begin
                if (at_pos)
                begin
                    entry_next = ctrl.value;
                    valid_next = 1'b1;
                end
                else
                begin
                    entry_next = prev.entry;
                    valid_next = prev.valid;
                end
            end
        end
        else if (ctrl.rot && valid_reg)
        begin
            // last occupied cell wraps around to the head value
            entry_next = next.valid ? next.entry : head;
        end
        link.entry = entry_reg;
        link.valid = valid_reg;
        link.ahead = ahead;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/magnitude_sorted_set_insert_unit.sv */
// magnitude sorted set, insert and dump
// item channel: item_valid / item_stall / item. kind insert puts value into a
//   chain of DEPTH cells ordered by descending magnitude, positive first on a
//   tie; a value already held is ignored. kind dump reads the set out.
// result channel: result_valid / result_stall / result, one transaction per
//   stored entry for a dump, last set on the final one; an empty set gives a
//   single transaction with empty_res set and entry zero. overflowed is the
//   sticky flag, set once a value was lost because all cells were full.
// inserts: a new item may follow an insert directly, since item_stall stays
//   low outside a dump; every cell compares against the new value at once and
//   shifts back by one neighbor. inserts produce no result.
// a dump rotates the chain once per result through the head cell, so it
//   holds item_stall high until its last result is written to the output
//   register; acceptance enters ST_DUMP, where each step registers a result.
// the result is held in an output register; while a valid result is stalled the
//   dump pauses and the transaction on the port does not change.
// reset clears the cell valid bits, the occupancy count and the overflow
//   flag; no clearing pass is needed.
module magnitude_sorted_set_insert_unit #(
    parameter int unsigned DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  msi_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output msi_pkg::result_t result
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       occ_reg;
    logic [CW-1:0]       occ_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                rvalid_reg;
    logic                rvalid_next;
    msi_pkg::result_t    result_reg;
    msi_pkg::result_t    result_next;

    msi_pkg::cell_ctrl_t ctrl;
    msi_pkg::cell_link_t links [DEPTH];
    logic [DEPTH-1:0]    hits;
    logic                accept;
    logic                dup;
    logic                full;
    logic                slot_free;
    logic                step;
    logic                is_last;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign dup          = |hits;
    assign full         = links[DEPTH-1].valid;
    assign slot_free    = !rvalid_reg || !result_stall;
    assign step         = (state_reg == ST_DUMP) && slot_free;
    assign is_last      = (cnt_reg == occ_reg - CW'(1));

    assign ctrl.value   = item.value;
    assign ctrl.ins     = accept && (item.kind == msi_pkg::KIND_INSERT) && !dup;
    assign ctrl.rot     = step && (occ_reg != '0);

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        msi_pkg::cell_link_t prev_l;
        msi_pkg::cell_link_t next_l;
        if (i == 0)
        begin : g_first
            assign prev_l = '{entry: '0, valid: 1'b0, ahead: 1'b1};
        end
        else
        begin : g_prev
            assign prev_l = links[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_end
            assign next_l = '{entry: '0, valid: 1'b0, ahead: 1'b0};
        end
        else
        begin : g_next
            assign next_l = links[i+1];
        end
        msi_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .prev  (prev_l),
            .next  (next_l),
            .head  (links[0].entry),
            .link  (links[i]),
            .hit   (hits[i])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        rvalid_next = rvalid_reg && result_stall;
        result_next = result_reg;
        if (ctrl.ins && full)
        begin
            ovf_next = 1'b1;
        end
        else if (ctrl.ins)
        begin
            occ_next = occ_reg + CW'(1);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == msi_pkg::KIND_DUMP))
                begin
                    state_next = ST_DUMP;
                    cnt_next   = '0;
                end
            end
            ST_DUMP:
            begin
                if (step)
                begin
                    rvalid_next            = 1'b1;
                    result_next.overflowed = ovf_reg;
                    if (occ_reg == '0)
                    begin
                        result_next.entry     = '0;
                        result_next.last      = 1'b1;
                        result_next.empty_res = 1'b1;
                        state_next            = ST_IDLE;
                    end
                    else
                    begin
                        result_next.entry     = links[0].entry;
                        result_next.last      = is_last;
                        result_next.empty_res = 1'b0;
                        cnt_next              = cnt_reg + CW'(1);
                        if (is_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* rtl/core/msi_checker.sv */
`include "magnitude_sorted_set_insert_unit_defines.svh"

module msi_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input msi_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input msi_pkg::result_t result
);

    `MSI_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result transaction changed")

    `MSI_ASSERT(a_empty_form, result_valid && result.empty_res |-> result.last && (result.entry == '0), "empty result not marked last or entry nonzero")

    `MSI_ASSERT_NEXT(a_dump_busy, item_valid && !item_stall && (item.kind == msi_pkg::KIND_DUMP), item_stall, "item taken right after a dump")

    `MSI_ASSERT_NEXT(a_dump_stream, result_valid && !result_stall && !result.last, result_valid, "gap inside a dump")

endmodule

bind magnitude_sorted_set_insert_unit msi_checker u_msi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
